// ===== rtl/lsta_pkg.sv =====
// shared types and constants for the linear scan temp allocator
package lsta_pkg;

  localparam int unsigned MaxLabelsDef   = 32;
  localparam int unsigned PosWidthDef    = 16;
  localparam int unsigned LabelWidth     = 5;
  localparam int unsigned NeededWidth    = 6;

  typedef enum logic [2:0] {
    StLoad,
    StSortScan,
    StSortPick,
    StAllocScan,
    StAllocPick,
    StEmit
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_en;
    logic sort_start;
    logic sort_step;
    logic sort_pick;
    logic alloc_start;
    logic alloc_step;
    logic alloc_pick;
    logic emit_start;
    logic emit_step;
    logic clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sort_scan_done;
    logic sort_found;
    logic alloc_scan_done;
    logic alloc_done;
    logic emit_last;
  } status_t;

endpackage

// ===== rtl/lsta_ctrl.sv =====
// control state machine for the linear scan temp allocator
module lsta_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             in_last_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lsta_pkg::cmd_t    cmd_o,
  input  lsta_pkg::status_t sts_i
);
  import lsta_pkg::*;

  state_e state_q, state_d;
  logic   in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StLoad: begin
        if (in_acc && in_last_i) state_d = StSortScan;
      end
      StSortScan: begin
        if (sts_i.sort_scan_done) state_d = StSortPick;
      end
      StSortPick: begin
        if (sts_i.sort_found) state_d = StSortScan;
        else                  state_d = StAllocScan;
      end
      StAllocScan: begin
        if (sts_i.alloc_done)           state_d = StEmit;
        else if (sts_i.alloc_scan_done) state_d = StAllocPick;
      end
      StAllocPick: state_d = StAllocScan;
      StEmit: begin
        if (out_acc && sts_i.emit_last) state_d = StLoad;
      end
      default: state_d = StLoad;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      StLoad: begin
        in_stall_o    = 1'b0;
        cmd_o.load_en = in_acc;
        cmd_o.sort_start = in_acc && in_last_i;
      end
      StSortScan:  cmd_o.sort_step = 1'b1;
      StSortPick: begin
        cmd_o.sort_pick   = 1'b1;
        cmd_o.alloc_start = !sts_i.sort_found;
      end
      StAllocScan: begin
        cmd_o.alloc_step = 1'b1;
        cmd_o.emit_start = sts_i.alloc_done;
      end
      StAllocPick: cmd_o.alloc_pick = 1'b1;
      StEmit: begin
        out_valid_o     = 1'b1;
        cmd_o.emit_step = out_acc;
        cmd_o.clear     = out_acc && sts_i.emit_last;
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("input open while results pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && out_acc && sts_i.emit_last) |=> state_q == StLoad)
    else $error("run did not end after final result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLoad && in_acc && in_last_i) |=> state_q == StSortScan)
    else $error("last transaction did not start sorting");
endmodule

// ===== rtl/lsta_dpath.sv =====
// label table, sorter, allocator and result datapath
module lsta_dpath #(
  parameter int unsigned MaxLabels = lsta_pkg::MaxLabelsDef,
  parameter int unsigned PosWidth  = lsta_pkg::PosWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lsta_pkg::cmd_t                       cmd_i,
  output lsta_pkg::status_t                    sts_o,
  input  logic [PosWidth-1:0]                  position_i,
  input  logic [lsta_pkg::LabelWidth-1:0]      label_i,
  output logic [lsta_pkg::LabelWidth-1:0]      label_out_o,
  output logic [lsta_pkg::LabelWidth-1:0]      register_index_o,
  output logic                                used_o,
  output logic [lsta_pkg::NeededWidth-1:0]     registers_needed_o,
  output logic                                final_res_o
);
  import lsta_pkg::*;

  localparam int unsigned IdxW = (MaxLabels > 1) ? $clog2(MaxLabels) : 1;
  localparam int unsigned CntW = $clog2(MaxLabels + 1);

  logic [MaxLabels-1:0] seen_q, taken_q, busy_q;
  logic [PosWidth-1:0]  first_q [MaxLabels];
  logic [PosWidth-1:0]  lastp_q [MaxLabels];
  logic [PosWidth-1:0]  rend_q  [MaxLabels];
  logic [IdxW-1:0]      areg_q  [MaxLabels];
  logic [IdxW-1:0]      order_q [MaxLabels];

  logic [CntW-1:0]      scan_q;   // table walk index
  logic [CntW-1:0]      n_q;      // labels ordered
  logic [CntW-1:0]      k_q;      // allocation cursor
  logic                 found_q;
  logic [IdxW-1:0]      best_q;
  logic [IdxW-1:0]      top_q;
  logic                 any_q;
  logic [CntW-1:0]      needed_q;
  logic [CntW-1:0]      emit_q;

  logic                 lab_ok;
  logic [IdxW-1:0]      lab_idx, scan_idx, cur_lab, emit_idx;
  logic                 scan_end, blocked;

  assign lab_ok   = {{(32-LabelWidth){1'b0}}, label_i} < MaxLabels;
  assign lab_idx  = IdxW'(label_i);
  assign scan_idx = scan_q[IdxW-1:0];
  assign scan_end = scan_q == CntW'(MaxLabels - 1);
  assign cur_lab  = order_q[k_q[IdxW-1:0]];
  assign emit_idx = emit_q[IdxW-1:0];
  assign blocked  = busy_q[scan_idx] && (rend_q[scan_idx] >= first_q[cur_lab]) && !scan_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      taken_q <= '0;
      busy_q  <= '0;
      scan_q  <= '0;
      n_q     <= '0;
      k_q     <= '0;
      found_q <= 1'b0;
      top_q   <= '0;
      any_q   <= 1'b0;
      needed_q <= '0;
      emit_q  <= '0;
    end else begin
      if (cmd_i.load_en && lab_ok) begin
        if (!seen_q[lab_idx]) begin
          seen_q[lab_idx]  <= 1'b1;
          first_q[lab_idx] <= position_i;
        end
        lastp_q[lab_idx] <= position_i;
        if (!any_q || lab_idx > top_q) top_q <= lab_idx;
        any_q <= 1'b1;
      end
      if (cmd_i.sort_start) begin
        scan_q  <= '0;
        found_q <= 1'b0;
        n_q     <= '0;
      end
      if (cmd_i.sort_step) begin
        if (seen_q[scan_idx] && !taken_q[scan_idx] &&
            (!found_q || first_q[scan_idx] < first_q[best_q])) begin
          best_q  <= scan_idx;
          found_q <= 1'b1;
        end
        if (!scan_end) scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.sort_pick) begin
        if (found_q) begin
          taken_q[best_q] <= 1'b1;
          order_q[n_q[IdxW-1:0]] <= best_q;
          n_q <= n_q + 1'b1;
        end
        scan_q  <= '0;
        found_q <= 1'b0;
      end
      if (cmd_i.alloc_start) begin
        k_q      <= '0;
        scan_q   <= '0;
        needed_q <= '0;
      end
      if (cmd_i.alloc_step && !sts_o.alloc_done && blocked) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.alloc_pick) begin
        areg_q[cur_lab] <= scan_idx;
        busy_q[scan_idx] <= 1'b1;
        rend_q[scan_idx] <= lastp_q[cur_lab];
        if (scan_q + 1'b1 > needed_q) needed_q <= scan_q + 1'b1;
        k_q    <= k_q + 1'b1;
        scan_q <= '0;
      end
      if (cmd_i.emit_start) emit_q <= '0;
      if (cmd_i.emit_step)  emit_q <= emit_q + 1'b1;
      if (cmd_i.clear) begin
        seen_q  <= '0;
        taken_q <= '0;
        busy_q  <= '0;
        any_q   <= 1'b0;
        top_q   <= '0;
      end
    end
  end

  always_comb begin
    sts_o.sort_scan_done  = scan_end;
    sts_o.sort_found      = found_q;
    sts_o.alloc_done      = k_q == n_q;
    sts_o.alloc_scan_done = !blocked;
    sts_o.emit_last       = emit_idx == top_q;
  end

  assign label_out_o      = LabelWidth'(emit_idx);
  assign used_o           = seen_q[emit_idx];
  assign register_index_o = seen_q[emit_idx] ? LabelWidth'(areg_q[emit_idx]) : '0;
  assign final_res_o      = emit_idx == top_q;
  assign registers_needed_o = (final_res_o && any_q) ? NeededWidth'(needed_q) : '0;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_pick |-> n_q > k_q)
    else $error("allocation past ordered labels");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (seen_q == '0 && busy_q == '0))
    else $error("tables not cleared after run");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sort_pick && found_q |-> !taken_q[best_q])
    else $error("label ordered twice");
endmodule

// ===== rtl/linear_scan_temp_allocator.sv =====
// top level of the linear scan temp allocator
// usage:
// - input channel (in_valid_i/in_stall_o) carries one transaction per
//   label occurrence: position_i, label_i, last_i; positions nondecreasing
// - during loading one transaction is taken per cycle
// - the transaction with last_i set ends the run; input then stalls
// - sorting walks the label table one entry a cycle, once per ordered
//   label and once more to find that no label is left
// - allocation probes registers from 0 up for each label in sort order
//   and gives each label the first register that is free for it
// - output channel (out_valid_o/out_stall_i) then gives one transaction per
//   label from 0 up to the highest label seen, one per cycle when not stalled
// - final_res_o marks the last one, where registers_needed_o is valid
// - a stalled result holds; the block waits, then clears its tables and
//   reopens the input after the final result is taken
// - reset empties all tables and opens the input for loading
module linear_scan_temp_allocator #(
  parameter int unsigned MAX_LABELS     = lsta_pkg::MaxLabelsDef,
  parameter int unsigned POSITION_WIDTH = lsta_pkg::PosWidthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [POSITION_WIDTH-1:0]       position_i,
  input  logic [lsta_pkg::LabelWidth-1:0] label_i,
  input  logic                            last_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [lsta_pkg::LabelWidth-1:0] label_out_o,
  output logic [lsta_pkg::LabelWidth-1:0] register_index_o,
  output logic                            used_o,
  output logic [lsta_pkg::NeededWidth-1:0] registers_needed_o,
  output logic                            final_res_o
);
  import lsta_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // sequencer for load, sort, allocate and emit phases
  lsta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_last_i   (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // label tables, register tables and result mux
  lsta_dpath #(
    .MaxLabels (MAX_LABELS),
    .PosWidth  (POSITION_WIDTH)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .position_i         (position_i),
    .label_i            (label_i),
    .label_out_o        (label_out_o),
    .register_index_o   (register_index_o),
    .used_o             (used_o),
    .registers_needed_o (registers_needed_o),
    .final_res_o        (final_res_o)
  );
endmodule

// ===== test/linear_scan_temp_allocator_tb.sv =====
// testbench for the linear scan temp allocator: directed and random label occurrences, predicted mappings
module linear_scan_temp_allocator_tb;
  import lsta_pkg::*;

  localparam int unsigned NumLabels = MaxLabelsDef;

  // one label occurrence
  typedef struct packed {
    logic [PosWidthDef-1:0] position;
    logic [LabelWidth-1:0]  label;
    logic                   last;
  } occurrence_t;

  // one label mapping
  typedef struct packed {
    logic [LabelWidth-1:0]  label_out;
    logic [LabelWidth-1:0]  register_index;
    logic                   used;
    logic [NeededWidth-1:0] registers_needed;
    logic                   final_res;
  } mapping_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [PosWidthDef-1:0] position_i = '0;
  logic [LabelWidth-1:0] label_i = '0;
  logic last_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [LabelWidth-1:0] label_out_o;
  logic [LabelWidth-1:0] register_index_o;
  logic used_o;
  logic [NeededWidth-1:0] registers_needed_o;
  logic final_res_o;

  linear_scan_temp_allocator u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .position_i, .label_i, .last_i,
    .out_valid_o, .out_stall_i, .label_out_o, .register_index_o, .used_o,
    .registers_needed_o, .final_res_o
  );

  always #5 clk_i = ~clk_i;

  occurrence_t pending_occ[$];
  mapping_t    expected_map[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          any_failure = 1'b0;

  // shadow of the label table
  bit                     seen_q[NumLabels];
  logic [PosWidthDef-1:0] first_q[NumLabels];
  logic [PosWidthDef-1:0] last_q[NumLabels];

  // record one occurrence; on the closing one, allocate and queue the mappings
  task automatic predict_mappings(input occurrence_t occ);
    bit                     taken[NumLabels];
    bit                     reg_busy[NumLabels];
    logic [PosWidthDef-1:0] reg_end[NumLabels];
    int                     reg_of[NumLabels];
    int                     best, r, top, needed;
    bit                     found, any;
    mapping_t               m;
    if (!seen_q[occ.label]) begin
      seen_q[occ.label] = 1'b1;
      first_q[occ.label] = occ.position;
    end
    last_q[occ.label] = occ.position;
    if (!occ.last) return;
    foreach (taken[i]) begin
      taken[i] = 1'b0;
      reg_busy[i] = 1'b0;
      reg_end[i] = '0;
      reg_of[i] = 0;
    end
    needed = 0;
    // pick by earliest first position, lower label wins ties
    for (int k = 0; k < NumLabels; k++) begin
      found = 1'b0;
      best = 0;
      for (int i = 0; i < NumLabels; i++) begin
        if (seen_q[i] && !taken[i] && (!found || first_q[i] < first_q[best])) begin
          best = i;
          found = 1'b1;
        end
      end
      if (!found) break;
      taken[best] = 1'b1;
      r = 0;
      while (r + 1 < NumLabels && reg_busy[r] && reg_end[r] >= first_q[best]) r++;
      reg_of[best] = r;
      reg_busy[r] = 1'b1;
      reg_end[r] = last_q[best];
      if (r + 1 > needed) needed = r + 1;
    end
    top = 0;
    any = 1'b0;
    for (int i = 0; i < NumLabels; i++) begin
      if (seen_q[i]) begin
        top = i;
        any = 1'b1;
      end
    end
    if (!any) needed = 0;
    for (int i = 0; i <= top; i++) begin
      m.label_out = LabelWidth'(i);
      m.register_index = seen_q[i] ? LabelWidth'(reg_of[i]) : '0;
      m.used = seen_q[i];
      m.registers_needed = (i == top) ? NeededWidth'(needed) : '0;
      m.final_res = (i == top);
      expected_map.push_back(m);
    end
    foreach (seen_q[i]) seen_q[i] = 1'b0;
  endtask

  // driver: presents pending transactions, idles at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_mappings({position_i, label_i, last_i});
        void'(pending_occ.pop_front());
      end
      if ((!in_valid_i || !in_stall_o) ) begin
        if (pending_occ.size() > (in_valid_i && !in_stall_o ? 0 : 0) &&
            $urandom_range(99) >= send_idle_pct && pending_occ.size() > 0) begin
          in_valid_i <= 1'b1;
          {position_i, label_i, last_i} <= pending_occ[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor: compares each taken mapping with the oldest prediction
  always @(posedge clk_i) begin
    mapping_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_map.size() == 0) begin
        $error("unexpected mapping for label %0d", label_out_o);
        any_failure = 1'b1;
      end else begin
        want = expected_map.pop_front();
        if (label_out_o !== want.label_out) begin
          $error("label_out expected %0d actual %0d", want.label_out, label_out_o);
          any_failure = 1'b1;
        end
        if (register_index_o !== want.register_index) begin
          $error("register_index expected %0d actual %0d", want.register_index,
                 register_index_o);
          any_failure = 1'b1;
        end
        if (used_o !== want.used) begin
          $error("used expected %0d actual %0d", want.used, used_o);
          any_failure = 1'b1;
        end
        if (registers_needed_o !== want.registers_needed) begin
          $error("registers_needed expected %0d actual %0d", want.registers_needed,
                 registers_needed_o);
          any_failure = 1'b1;
        end
        if (final_res_o !== want.final_res) begin
          $error("final_res expected %0d actual %0d", want.final_res, final_res_o);
          any_failure = 1'b1;
        end
      end
    end
  end

  // one run of occurrences with nondecreasing positions
  task automatic queue_run(input int count, input int label_hi, input int step_hi,
                           input int start);
    occurrence_t o;
    int p;
    p = start;
    for (int i = 0; i < count; i++) begin
      p = p + $urandom_range(step_hi);
      if (p > 65535) p = 65535;
      o.position = PosWidthDef'(p);
      o.label = LabelWidth'($urandom_range(label_hi));
      o.last = (i == count - 1);
      pending_occ.push_back(o);
    end
  endtask

  task automatic push_occ(input int p, input int l, input bit fin);
    occurrence_t o;
    o.position = PosWidthDef'(p);
    o.label = LabelWidth'(l);
    o.last = fin;
    pending_occ.push_back(o);
  endtask

  task automatic wait_drained();
    while (pending_occ.size() > 0 || in_valid_i || expected_map.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: only label zero
    push_occ(0, 0, 1'b1);
    // directed: unused labels in between, ties on first position, extremes
    push_occ(0, 31, 1'b0);
    push_occ(0, 3, 1'b0);
    push_occ(5, 7, 1'b0);
    push_occ(65535, 3, 1'b0);
    push_occ(65535, 31, 1'b1);
    // directed: disjoint intervals share a register; out of order positions
    push_occ(10, 1, 1'b0);
    push_occ(20, 1, 1'b0);
    push_occ(21, 2, 1'b0);
    push_occ(30, 2, 1'b0);
    push_occ(30, 4, 1'b0);
    push_occ(2, 4, 1'b0);
    push_occ(21, 5, 1'b1);
    // directed: every label live at once needs all registers
    for (int i = 0; i < 32; i++) push_occ(100 + i, i, 1'b0);
    for (int i = 0; i < 32; i++) push_occ(200, 31 - i, i == 31);
    // random runs, phases with input idling and output stalls mixed
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 76 : 17) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 76 : 17) : 0;
      for (int r = 0; r < 4; r++)
        queue_run($urandom_range(1, 20), $urandom_range(1) ? 31 : 7,
                  $urandom_range(1) ? 3 : 4000, $urandom_range(1) ? 0 : 60000);
    end
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (!any_failure) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lsta_pkg.sv
rtl/lsta_ctrl.sv
rtl/lsta_dpath.sv
rtl/linear_scan_temp_allocator.sv
test/linear_scan_temp_allocator_tb.sv
